// File: design/crank_angle_event_scheduler_macros.svh
// Assertion macros for the crank angle event scheduler.
// Pulled in by the top level; no other dependencies.
`ifndef CRANK_ANGLE_EVENT_SCHEDULER_MACROS_SVH
`define CRANK_ANGLE_EVENT_SCHEDULER_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CAES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CAES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/caes_pkg.sv
// Shared types and constants for the crank angle event scheduler.
// No dependencies.
package caes_pkg;

  localparam int SLOTS     = 16;
  localparam int CYLINDERS = 4;
  localparam int IDXW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [13:0] CYCLE_ANGLE = 14'd11520;
  localparam logic [12:0] REV_ANGLE   = 13'd5760;
  localparam logic [12:0] PITCH_RST   = 13'd96;
  localparam logic [13:0] TDC_RST     = 14'd1824;
  localparam logic [5:0]  MOD_STEPS   = 6'd8;   // 11520 << 8 exceeds any angle sum
  localparam logic [5:0]  DIV_STEPS   = 6'd45;  // 46-bit dividend

  localparam logic [2:0] REQ_TOOTH      = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE   = 3'd1;
  localparam logic [2:0] REQ_CANCEL_CYL = 3'd2;
  localparam logic [2:0] REQ_CANCEL_KND = 3'd3;
  localparam logic [2:0] REQ_CANCEL_ALL = 3'd4;

  localparam logic [2:0] ACT_NONE = 3'd0;

  localparam logic [1:0] CFG_PITCH = 2'd0;
  localparam logic [1:0] CFG_TDC   = 2'd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] value_us;
    logic [31:0] tooth_per;
    logic [7:0]  tooth_num;
    logic        revolution;
    logic        sync_ok;
    logic [1:0]  event_kind;
    logic [3:0]  cylinder;
    logic [13:0] angle;
    logic [15:0] rpm_value;
    logic [15:0] vbat_mv;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  cylinder;
    logic [13:0] angle;
    logic [31:0] pulse;
    logic [15:0] rpm;
    logic [15:0] vbat;
  } slot_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  fire_cylinder;
    logic [31:0] fire_delay;
    logic [31:0] fire_time_us;
    logic [31:0] pulse_us;
    logic [15:0] rpm_snapshot;
    logic [15:0] vbat_snapshot;
    logic        accepted;
    logic [4:0]  pending_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic capture;
    logic ang_load;
    logic mod_step;
    logic sched_write;
    logic cancel_all;
    logic idx_clr;
    logic idx_inc;
    logic chk_cancel;
    logic chk_fire;
    logic commit;
    logic sel_next;
    logic div_load;
    logic div_step;
    logic out_plain;
    logic out_fire;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       tooth_go;
    logic       sched_ok;
    logic       idx_last;
    logic       fire_any;
    logic       fire_last;
    logic       cnt_zero;
    logic       out_free;
  } sts_t;

endpackage

// File: design/crank_angle_event_scheduler.sv
// Crank angle event scheduler: slot table of armed events, fired on trigger teeth.
// One item at a time; plain requests are decoded and answered, cancel by cylinder or kind
// scans every slot. A tooth runs angle reduction, then a slot scan (each slot read in S_SRD,
// checked in S_SCK; single RAM read port), then a plain beat or, per fired event, a slot
// read and the 46-step delay divider; a stalled result beat adds its wait. rst clears the
// armed mask, sets tooth_pitch 96 and tdc_offset 1824; slot contents are not cleared.
`include "crank_angle_event_scheduler_macros.svh"
module crank_angle_event_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // value_us[31:0], tooth period[63:32], tooth number[71:64], revolution[72],
  // sync_ok[73], event_kind[75:74], cylinder[79:76], angle[93:80],
  // rpm_value[109:94], vbat_mv[125:110], zero pad
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fire_cylinder[3:0], fire delay[35:4], fire_time_us[67:36], pulse_us[99:68],
  // rpm_snapshot[115:100], vbat_snapshot[131:116], accepted[132],
  // pending_count[137:133], zero pad
  output logic [143:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // action
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [13:0]  cfg_data
);

  caes_pkg::req_t in_req;
  caes_pkg::cmd_t cmd;
  caes_pkg::sts_t sts;
  caes_pkg::res_t res;
  logic           beat_none;
  logic           beat_fire;

  assign cfg_ready = 1'b1;

  always_comb begin
    in_req.req_type   = s_axis_tuser;
    in_req.value_us   = s_axis_tdata[31:0];
    in_req.tooth_per  = s_axis_tdata[63:32];
    in_req.tooth_num  = s_axis_tdata[71:64];
    in_req.revolution = s_axis_tdata[72];
    in_req.sync_ok    = s_axis_tdata[73];
    in_req.event_kind = s_axis_tdata[75:74];
    in_req.cylinder   = s_axis_tdata[79:76];
    in_req.angle      = s_axis_tdata[93:80];
    in_req.rpm_value  = s_axis_tdata[109:94];
    in_req.vbat_mv    = s_axis_tdata[125:110];
  end

  caes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  caes_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_req    (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_res   (res)
  );

  assign m_axis_tuser = res.action;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {6'd0, res.pending_count, res.accepted, res.vbat_snapshot,
                         res.rpm_snapshot, res.pulse_us, res.fire_time_us,
                         res.fire_delay, res.fire_cylinder};

  assign beat_none = m_axis_tvalid && (m_axis_tuser == caes_pkg::ACT_NONE);
  assign beat_fire = m_axis_tvalid && (m_axis_tuser != caes_pkg::ACT_NONE);

  `CAES_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy accept")
  `CAES_ASSERT_SAME(a_plain_last, beat_none, m_axis_tlast, "plain beat not last")
  `CAES_ASSERT_SAME(a_fire_acc, beat_fire, !m_axis_tdata[132], "fired beat flagged accepted")
  `CAES_ASSERT_SAME(a_pend_range, m_axis_tvalid, m_axis_tdata[137:133] <= 5'(caes_pkg::SLOTS), "pending count beyond slots")

endmodule

// File: design/caes_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module caes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/caes_datapath.sv
// Datapath: slot table, armed/fire masks, angle reduction, delay divider, output register.
// Depends on caes_pkg and caes_ram.
module caes_datapath (
  input  logic              clk,
  input  logic              rst,
  input  caes_pkg::req_t    in_req,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [13:0]       cfg_wdata,
  input  caes_pkg::cmd_t    cmd,
  output caes_pkg::sts_t    sts,
  input  logic              out_ready,
  output logic              out_valid,
  output caes_pkg::res_t    out_res
);

  localparam int IW = caes_pkg::IDXW;
  localparam int SW = $bits(caes_pkg::slot_t);

  logic [12:0] pitch;
  logic [13:0] tdc;
  caes_pkg::req_t rq;
  logic [caes_pkg::SLOTS-1:0] armed;
  logic [caes_pkg::SLOTS-1:0] fire;
  logic [IW-1:0] idx;
  logic [21:0] angacc;
  logic [5:0]  cnt;
  logic [45:0] nq;
  logic [13:0] rem;
  logic        acc_flag;

  caes_pkg::slot_t rd;
  caes_pkg::slot_t wd;
  logic [SW-1:0]   rd_bits;
  logic [IW-1:0]   free_idx;
  logic            free_any;
  logic [IW-1:0]   fire_idx;
  logic [14:0]     dsum;
  logic [13:0]     fwd_dist;
  logic            in_win;
  logic [4:0]      pend;
  logic [21:0]     mod_sub;
  logic [13:0]     rem_sh;
  logic            rem_ge;
  logic [31:0]     delay;
  logic [caes_pkg::SLOTS-1:0] fire_rest;
  caes_pkg::res_t  plain_res;

  assign rd = caes_pkg::slot_t'(rd_bits);

  always_comb begin
    wd.kind     = rq.event_kind;
    wd.cylinder = rq.cylinder;
    wd.angle    = (rq.angle >= caes_pkg::CYCLE_ANGLE) ? rq.angle - caes_pkg::CYCLE_ANGLE
                                                      : rq.angle;
    wd.pulse    = rq.value_us;
    wd.rpm      = rq.rpm_value;
    wd.vbat     = rq.vbat_mv;
  end

  caes_ram #(.WIDTH(SW), .DEPTH(caes_pkg::SLOTS)) u_slots (
    .clk   (clk),
    .we    (cmd.sched_write),
    .waddr (free_idx),
    .wdata (wd),
    .raddr (idx),
    .rdata (rd_bits)
  );

  // lowest free slot and lowest pending fire
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    fire_idx = '0;
    pend     = '0;
    for (int i = caes_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!armed[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
      if (fire[i]) begin
        fire_idx = IW'(i);
      end
    end
    for (int i = 0; i < caes_pkg::SLOTS; i++) begin
      pend = pend + 5'(armed[i]);
    end
  end

  always_comb begin
    dsum = {1'b0, rd.angle} + {1'b0, caes_pkg::CYCLE_ANGLE} - {1'b0, angacc[13:0]};
    fwd_dist = (dsum >= {1'b0, caes_pkg::CYCLE_ANGLE})
             ? 14'(dsum - {1'b0, caes_pkg::CYCLE_ANGLE}) : dsum[13:0];
    in_win  = ({1'b0, fwd_dist} << 1) <= (15'(pitch) * 15'd3);
    mod_sub = 22'(caes_pkg::CYCLE_ANGLE) << cnt[3:0];
    rem_sh  = {rem[12:0], nq[45]};
    rem_ge  = rem_sh >= {1'b0, pitch};
    delay   = (pitch == '0) ? '0 : ((|nq[45:32]) ? 32'hFFFF_FFFF : nq[31:0]);
    fire_rest = fire;
    fire_rest[idx] = 1'b0;
  end

  always_comb begin
    plain_res               = '0;
    plain_res.action        = caes_pkg::ACT_NONE;
    plain_res.accepted      = acc_flag;
    plain_res.pending_count = pend;
    plain_res.last          = 1'b1;
  end

  always_comb begin
    sts.req       = rq.req_type;
    sts.tooth_go  = rq.sync_ok && (rq.tooth_per != '0);
    sts.sched_ok  = ({1'b0, rq.cylinder} < 5'(caes_pkg::CYLINDERS)) && free_any;
    sts.idx_last  = (idx == IW'(caes_pkg::SLOTS - 1));
    sts.fire_any  = |fire;
    sts.fire_last = ~|fire_rest;
    sts.cnt_zero  = (cnt == '0);
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch     <= caes_pkg::PITCH_RST;
      tdc       <= caes_pkg::TDC_RST;
      armed     <= '0;
      fire      <= '0;
      out_valid <= 1'b0;
      acc_flag  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          caes_pkg::CFG_PITCH: pitch <= cfg_wdata[12:0];
          caes_pkg::CFG_TDC:   tdc   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        fire     <= '0;
        acc_flag <= 1'b0;
      end
      if (cmd.sched_write) begin
        armed[free_idx] <= 1'b1;
        acc_flag        <= 1'b1;
      end
      if (cmd.cancel_all) begin
        armed <= '0;
      end
      if (cmd.chk_cancel && armed[idx]) begin
        if ((rq.req_type == caes_pkg::REQ_CANCEL_CYL) ? (rd.cylinder == rq.cylinder)
                                                      : (rd.kind == rq.event_kind)) begin
          armed[idx] <= 1'b0;
        end
      end
      if (cmd.chk_fire && armed[idx] && in_win) begin
        fire[idx] <= 1'b1;
      end
      if (cmd.commit) begin
        armed <= armed & ~fire;
      end
      if (cmd.out_fire) begin
        fire[idx] <= 1'b0;
      end
      if (cmd.out_plain || cmd.out_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq <= in_req;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end else if (cmd.sel_next) begin
      idx <= fire_idx;
    end
    if (cmd.ang_load) begin
      angacc <= 22'(rq.revolution ? caes_pkg::REV_ANGLE : 13'd0)
              + ({13'd0, rq.tooth_num} * {8'd0, pitch}) + 22'(tdc);
      cnt    <= caes_pkg::MOD_STEPS;
    end else if (cmd.mod_step) begin
      if (angacc >= mod_sub) begin
        angacc <= angacc - mod_sub;
      end
      cnt <= cnt - 1'b1;
    end else if (cmd.div_load) begin
      nq  <= {32'd0, fwd_dist} * {14'd0, rq.tooth_per};
      rem <= '0;
      cnt <= caes_pkg::DIV_STEPS;
    end else if (cmd.div_step) begin
      rem <= rem_ge ? rem_sh - {1'b0, pitch} : rem_sh;
      nq  <= {nq[44:0], rem_ge};
      cnt <= cnt - 1'b1;
    end
    if (cmd.out_plain) begin
      out_res <= plain_res;
    end else if (cmd.out_fire) begin
      out_res.action        <= {1'b0, rd.kind} + 3'd1;
      out_res.fire_cylinder <= rd.cylinder;
      out_res.fire_delay    <= delay;
      out_res.fire_time_us  <= rq.value_us + delay;
      out_res.pulse_us      <= rd.pulse;
      out_res.rpm_snapshot  <= rd.rpm;
      out_res.vbat_snapshot <= rd.vbat;
      out_res.accepted      <= 1'b0;
      out_res.pending_count <= pend;
      out_res.last          <= ~|fire_rest;
    end
  end

endmodule

// File: design/caes_ctrl.sv
// Controller state machine sequencing requests, slot scans and the delay divider.
// Depends on caes_pkg.
module caes_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  caes_pkg::sts_t sts,
  output caes_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PREP, S_MOD, S_SRD, S_SCK, S_COMMIT,
    S_NXT, S_FRD, S_FMUL, S_FDIV, S_FOUT, S_RESP
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.req) inside
          caes_pkg::REQ_TOOTH: begin
            state_next = sts.tooth_go ? S_PREP : S_RESP;
          end
          caes_pkg::REQ_SCHEDULE: begin
            cmd.sched_write = sts.sched_ok;
            state_next      = S_RESP;
          end
          caes_pkg::REQ_CANCEL_CYL, caes_pkg::REQ_CANCEL_KND: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_SRD;
          end
          caes_pkg::REQ_CANCEL_ALL: begin
            cmd.cancel_all = 1'b1;
            state_next     = S_RESP;
          end
          default: state_next = S_RESP;
        endcase
      end
      S_PREP: begin
        cmd.ang_load = 1'b1;
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.cnt_zero) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_SRD: state_next = S_SCK;
      S_SCK: begin
        if (sts.req == caes_pkg::REQ_TOOTH) begin
          cmd.chk_fire = 1'b1;
        end else begin
          cmd.chk_cancel = 1'b1;
        end
        if (sts.idx_last) begin
          state_next = (sts.req == caes_pkg::REQ_TOOTH) ? S_COMMIT : S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sts.fire_any ? S_NXT : S_RESP;
      end
      S_NXT: begin
        cmd.sel_next = 1'b1;
        state_next   = S_FRD;
      end
      S_FRD: state_next = S_FMUL;
      S_FMUL: begin
        cmd.div_load = 1'b1;
        state_next   = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_zero) begin
          state_next = S_FOUT;
        end
      end
      S_FOUT: begin
        if (sts.out_free) begin
          cmd.out_fire = 1'b1;
          state_next   = sts.fire_last ? S_IDLE : S_NXT;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_plain = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: verif/crank_angle_event_scheduler_test.sv
// Self-checking testbench for the crank angle event scheduler.
// Needs caes_pkg and the crank_angle_event_scheduler top level; holds its own slot-table model.
`timescale 1ns / 1ps

class fire_scoreboard;
  caes_pkg::res_t pending_q[$];
  int mismatches;

  bit [12:0] pitch;
  bit [13:0] tdc;
  bit        armed[caes_pkg::SLOTS];
  caes_pkg::slot_t slots[caes_pkg::SLOTS];

  function new();
    pitch = 13'd96;
    tdc = 14'd1824;
    mismatches = 0;
    foreach (armed[i]) armed[i] = 1'b0;
  endfunction

  function void note_config(bit [1:0] idx, bit [13:0] data);
    if (idx == caes_pkg::CFG_PITCH) pitch = data[12:0];
    else if (idx == caes_pkg::CFG_TDC) tdc = data;
  endfunction

  // Update the slot table for one request beat and queue what it should produce.
  function void note_request(caes_pkg::req_t rq);
    caes_pkg::res_t r;
    caes_pkg::res_t fired[$];
    bit acc;
    int unsigned cur, fwd_dist;
    bit [63:0] dly;
    bit [4:0] cnt;
    acc = 1'b0;
    case (rq.req_type)
      caes_pkg::REQ_TOOTH: begin
        if (rq.sync_ok && rq.tooth_per != 0) begin
          cur = ((rq.revolution ? 5760 : 0) + rq.tooth_num * pitch + tdc) % 11520;
          for (int i = 0; i < caes_pkg::SLOTS; i++) begin
            if (!armed[i]) continue;
            fwd_dist = (slots[i].angle + 11520 - cur) % 11520;
            if (2 * fwd_dist > 3 * pitch) continue;
            if (pitch == 0) dly = 0;
            else begin
              dly = (64'(fwd_dist) * rq.tooth_per) / pitch;
              if (dly > 64'hFFFF_FFFF) dly = 64'hFFFF_FFFF;
            end
            r = '0;
            r.action = slots[i].kind + 3'd1;
            r.fire_cylinder = slots[i].cylinder;
            r.fire_delay = dly[31:0];
            r.fire_time_us = rq.value_us + dly[31:0];
            r.pulse_us = slots[i].pulse;
            r.rpm_snapshot = slots[i].rpm;
            r.vbat_snapshot = slots[i].vbat;
            fired.push_back(r);
            armed[i] = 1'b0;
          end
        end
      end
      caes_pkg::REQ_SCHEDULE: begin
        if (rq.cylinder < caes_pkg::CYLINDERS) begin
          for (int i = 0; i < caes_pkg::SLOTS; i++) begin
            if (!armed[i]) begin
              slots[i].kind = rq.event_kind;
              slots[i].cylinder = rq.cylinder;
              slots[i].angle = 14'(rq.angle % 11520);
              slots[i].pulse = rq.value_us;
              slots[i].rpm = rq.rpm_value;
              slots[i].vbat = rq.vbat_mv;
              armed[i] = 1'b1;
              acc = 1'b1;
              break;
            end
          end
        end
      end
      caes_pkg::REQ_CANCEL_CYL:
        foreach (armed[i]) if (armed[i] && slots[i].cylinder == rq.cylinder) armed[i] = 1'b0;
      caes_pkg::REQ_CANCEL_KND:
        foreach (armed[i]) if (armed[i] && slots[i].kind == rq.event_kind) armed[i] = 1'b0;
      caes_pkg::REQ_CANCEL_ALL:
        foreach (armed[i]) armed[i] = 1'b0;
      default: ;
    endcase
    if (fired.size() == 0) begin
      r = '0;
      r.action = caes_pkg::ACT_NONE;
      r.accepted = acc;
      fired.push_back(r);
    end
    cnt = 0;
    foreach (armed[i]) cnt += 5'(armed[i]);
    foreach (fired[k]) begin
      fired[k].pending_count = cnt;
      fired[k].last = (k == fired.size() - 1);
      pending_q.push_back(fired[k]);
    end
  endfunction

  function void check_result(caes_pkg::res_t got);
    caes_pkg::res_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %p", got);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
    end
  endfunction
endclass

module crank_angle_event_scheduler_test;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [13:0] cfg_data;

  fire_scoreboard sb;
  int unsigned cycles;

  crank_angle_event_scheduler u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Result side: random stall per beat, check on each accepted beat.
  initial begin
    caes_pkg::res_t got;
    int w;
    m_axis_tready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      w = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk iff m_axis_tvalid);
      got.action = m_axis_tuser;
      got.fire_cylinder = m_axis_tdata[3:0];
      got.fire_delay = m_axis_tdata[35:4];
      got.fire_time_us = m_axis_tdata[67:36];
      got.pulse_us = m_axis_tdata[99:68];
      got.rpm_snapshot = m_axis_tdata[115:100];
      got.vbat_snapshot = m_axis_tdata[131:116];
      got.accepted = m_axis_tdata[132];
      got.pending_count = m_axis_tdata[137:133];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // tvalid stays high after the accepting edge; the next call drops it if it waits, or drain() does.
  task automatic send_req(caes_pkg::req_t rq);
    int w;
    w = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= rq.req_type;
    s_axis_tdata <= {2'b0, rq.vbat_mv, rq.rpm_value, rq.angle, rq.cylinder, rq.event_kind,
                     rq.sync_ok, rq.revolution, rq.tooth_num, rq.tooth_per,
                     rq.value_us};
    @(posedge clk iff s_axis_tready);
    sb.note_request(rq);
  endtask

  // cfg_valid stays high after the write; the caller drops it after the last one.
  task automatic write_cfg(bit [1:0] idx, bit [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic caes_pkg::req_t rand_req();
    caes_pkg::req_t rq;
    rq.req_type = 3'($urandom_range(0, 7));
    rq.value_us = $urandom;
    rq.tooth_per = $urandom;
    rq.tooth_num = 8'($urandom);
    rq.revolution = 1'($urandom);
    rq.sync_ok = 1'($urandom);
    rq.event_kind = 2'($urandom);
    rq.cylinder = 4'($urandom);
    rq.angle = 14'($urandom);
    rq.rpm_value = 16'($urandom);
    rq.vbat_mv = 16'($urandom);
    return rq;
  endfunction

  function automatic caes_pkg::req_t sched(bit [3:0] cyl, bit [13:0] ang, bit [1:0] kind);
    caes_pkg::req_t rq;
    rq = rand_req();
    rq.req_type = caes_pkg::REQ_SCHEDULE;
    rq.cylinder = cyl;
    rq.angle = ang;
    rq.event_kind = kind;
    return rq;
  endfunction

  function automatic caes_pkg::req_t tooth(bit [7:0] idx, bit rev, bit [31:0] per);
    caes_pkg::req_t rq;
    rq = rand_req();
    rq.req_type = caes_pkg::REQ_TOOTH;
    rq.tooth_num = idx;
    rq.revolution = rev;
    rq.sync_ok = 1'b1;
    rq.tooth_per = per;
    return rq;
  endfunction

  // Angle of a tooth under the model's current settings, for aiming events.
  function automatic int unsigned aim_angle(bit [7:0] idx, bit rev);
    return ((rev ? 5760 : 0) + idx * sb.pitch + sb.tdc) % 11520;
  endfunction

  initial begin
    caes_pkg::req_t rq;
    bit [12:0] pitches[5];
    bit [13:0] tdcs[5];
    int unsigned base;
    bit [7:0] ti;
    bit rv;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the table, overflow, bad cylinder, angle wrap, cancels, firing.
    for (int i = 0; i < 16; i++)
      send_req(sched(4'(i % 4), 14'(aim_angle(8'd0, 1'b0) + i * 9), 2'(i % 4)));
    send_req(sched(4'd0, 14'd100, 2'd0));       // table full
    send_req(sched(4'd15, 14'd100, 2'd0));      // bad cylinder
    rq = tooth(8'd0, 1'b0, 32'd0); send_req(rq);          // zero period
    rq = tooth(8'd0, 1'b0, 32'd1000); rq.sync_ok = 1'b0; send_req(rq);
    rq = tooth(8'd0, 1'b0, 32'hFFFF_FFFF); send_req(rq);
    rq = rand_req(); rq.req_type = caes_pkg::REQ_CANCEL_CYL; rq.cylinder = 4'd1; send_req(rq);
    rq = rand_req(); rq.req_type = caes_pkg::REQ_CANCEL_KND; rq.event_kind = 2'd2; send_req(rq);
    send_req(sched(4'd3, 14'h3FFF, 2'd3));      // angle above 720 degrees
    rq = rand_req(); rq.req_type = REQ_UNKNOWN; send_req(rq);
    rq = rand_req(); rq.req_type = caes_pkg::REQ_CANCEL_ALL; send_req(rq);
    drain();

    pitches = '{13'd1, 13'd5760, 13'd0, 13'd8191, 13'd96};
    tdcs = '{14'd0, 14'd11519, 14'd16383, 14'd500, 14'd1824};
    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(caes_pkg::CFG_PITCH, {1'b0, pitches[ph]});
      write_cfg(caes_pkg::CFG_TDC, tdcs[ph]);
      if (ph == 0) write_cfg(caes_pkg::CFG_PITCH, 14'h3FFF);   // upper bit dropped
      if (ph == 0) write_cfg(caes_pkg::CFG_PITCH, {1'b0, pitches[ph]});
      cfg_valid <= 1'b0;
      for (int n = 0; n < 21; n++) begin
        ti = 8'($urandom);
        rv = 1'($urandom);
        base = aim_angle(ti, rv);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            rq = sched(4'($urandom_range(0, 4)),
                       14'((base + $urandom_range(0, 2 * sb.pitch + 2)) % 11520),
                       2'($urandom));
            send_req(rq);
          end
          4, 5, 6: begin
            rq = tooth(ti, rv, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000));
            if ($urandom_range(0, 7) == 0) rq.sync_ok = 1'b0;
            send_req(rq);
          end
          7: begin
            rq = rand_req();
            rq.req_type = 3'($urandom_range(caes_pkg::REQ_CANCEL_CYL, caes_pkg::REQ_CANCEL_ALL));
            send_req(rq);
          end
          default: send_req(rand_req());
        endcase
      end
      drain();
    end
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
